FILE: hdl/pfmt_pkg.sv
// Shared types, constants and helpers for the printf integer formatter.
`timescale 1ns / 1ps
package pfmt_pkg;

   localparam int ARG_W      = 32;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int NUM_CELLS  = 10;  // enough decimal digits for 32 bits
   localparam int NUM_NIBBLE = ARG_W / DIGIT_W;
   localparam int BIT_CNT_W  = $clog2(ARG_W);
   localparam int DIG_CNT_W  = $clog2(NUM_CELLS + 1);

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X_UP    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_A_UP    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_A_LO    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
   localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
   localparam logic [CHAR_W-1:0] CH_P       = 8'h70;
   localparam logic [CHAR_W-1:0] CH_U       = 8'h75;
   localparam logic [CHAR_W-1:0] CH_X_LO    = 8'h78;

   // cell operations
   typedef logic [1:0] cell_op_type;
   localparam cell_op_type OP_HOLD   = 2'd0;
   localparam cell_op_type OP_LOAD   = 2'd1;
   localparam cell_op_type OP_DABBLE = 2'd2;
   localparam cell_op_type OP_SHIFT  = 2'd3;

   typedef struct packed {
      cell_op_type op;
      logic        bit_in;
   } cell_ctl_type;

   typedef struct packed {
      logic [CHAR_W-1:0] fmt_char;
      logic [ARG_W-1:0]  arg;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last;
   } rsp_type;

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
      logic [CHAR_W-1:0] base;
      base = upper ? CH_A_UP : CH_A_LO;
      if (d < 4'd10) begin
         digit_ascii = CH_ZERO + CHAR_W'(d);
      end else begin
         digit_ascii = base + CHAR_W'(d - 4'd10);
      end
   endfunction

endpackage

FILE: hdl/pfmt_cell.sv
// One digit cell: hold, load, double-dabble shift, or whole-digit shift toward the top.
`timescale 1ns / 1ps
module pfmt_cell
   import pfmt_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [DIGIT_W-1:0] load_digit,
   input  logic [DIGIT_W-1:0] digit_in,
   output logic [DIGIT_W-1:0] digit_out,
   output logic               carry_out
);

   logic [DIGIT_W-1:0] digit_ff, digit_in_next;
   logic [DIGIT_W-1:0] adjusted;

   // add 3 before the shift so the digit stays decimal
   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adjusted[DIGIT_W-1];
   assign digit_out = digit_ff;

   always_comb begin
      case (ctl.op)
         OP_LOAD:   digit_in_next = load_digit;
         OP_DABBLE: digit_in_next = {adjusted[DIGIT_W-2:0], ctl.bit_in};
         OP_SHIFT:  digit_in_next = digit_in;
         default:   digit_in_next = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

FILE: hdl/printf_integer_formatter.sv
// Top level: format decoder, prefix emitter and digit cell chain with output register.
// A plain character, %c or %% passes through the prefix state into the output register.
// Decimal: a minus prefix for negative %d, then double-dabble over the 10-cell chain, then
// the digit phase (leading zeros drop without output). Hex: a 0x prefix for %p, then digits.
// One item at a time; the next transfer is taken the cycle after its last character is
// registered. Reset clears the pending percent flag, the sequencer and the output valid.
`timescale 1ns / 1ps
module printf_integer_formatter
   import pfmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PREFIX = 2'd1;
   localparam logic [1:0] ST_DABBLE = 2'd2;
   localparam logic [1:0] ST_DIGITS = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic                 pending_ff, pending_in;
   logic [1:0]           pre_cnt_ff, pre_cnt_in;
   logic [CHAR_W-1:0]    pre0_ff, pre0_in, pre1_ff, pre1_in;
   logic                 has_digits_ff, has_digits_in;
   logic                 hex_ff, hex_in;
   logic                 upper_ff, upper_in;
   logic [ARG_W-1:0]     mag_ff, mag_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                 started_ff, started_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 can_emit, emit_go, emit_last, load_hex, pend_v, show;
   logic [CHAR_W-1:0]    emit_char, ch;
   logic [DIGIT_W-1:0]   top_digit;
   cell_op_type          cell_op;

   logic [DIGIT_W-1:0]   cell_digit [NUM_CELLS];
   logic                 cell_carry [NUM_CELLS];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign ch        = req_data.fmt_char;
   assign pend_v    = pending_ff && !req_data.restart;
   assign top_digit = cell_digit[NUM_CELLS-1];
   assign show      = started_ff || (top_digit != '0) || (dig_cnt_ff == DIG_CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      pre_cnt_in    = pre_cnt_ff;
      pre0_in       = pre0_ff;
      pre1_in       = pre1_ff;
      has_digits_in = has_digits_ff;
      hex_in        = hex_ff;
      upper_in      = upper_ff;
      mag_in        = mag_ff;
      bit_cnt_in    = bit_cnt_ff;
      dig_cnt_in    = dig_cnt_ff;
      started_in    = started_ff;
      cell_op       = OP_HOLD;
      load_hex      = 1'b0;
      emit_go       = 1'b0;
      emit_char     = pre0_ff;
      emit_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cell_op    = OP_LOAD;
               bit_cnt_in = '0;
               dig_cnt_in = DIG_CNT_W'(NUM_CELLS);
               started_in = 1'b0;
               pre1_in    = CH_NUL;
               if (ch == CH_NUL) begin
                  pending_in = 1'b0;
               end else if (!pend_v) begin
                  if (ch == CH_PERCENT) begin
                     pending_in = 1'b1;
                  end else begin
                     pending_in    = 1'b0;
                     pre0_in       = ch;
                     pre_cnt_in    = 2'd1;
                     has_digits_in = 1'b0;
                     state_in      = ST_PREFIX;
                  end
               end else begin
                  pending_in = 1'b0;
                  case (ch)
                     CH_C, CH_PERCENT: begin
                        pre0_in       = (ch == CH_C) ? req_data.arg[CHAR_W-1:0] : CH_PERCENT;
                        pre_cnt_in    = 2'd1;
                        has_digits_in = 1'b0;
                        state_in      = ST_PREFIX;
                     end
                     CH_P: begin
                        pre0_in       = CH_ZERO;
                        pre1_in       = CH_X_LO;
                        pre_cnt_in    = 2'd2;
                        has_digits_in = 1'b1;
                        hex_in        = 1'b1;
                        upper_in      = 1'b0;
                        load_hex      = 1'b1;
                        state_in      = ST_PREFIX;
                     end
                     CH_X_LO, CH_X_UP: begin
                        hex_in   = 1'b1;
                        upper_in = (ch == CH_X_UP);
                        load_hex = 1'b1;
                        state_in = ST_DIGITS;
                     end
                     CH_D: begin
                        hex_in   = 1'b0;
                        upper_in = 1'b0;
                        if (req_data.arg[ARG_W-1]) begin
                           mag_in        = ~req_data.arg + ARG_W'(1);
                           pre0_in       = CH_MINUS;
                           pre_cnt_in    = 2'd1;
                           has_digits_in = 1'b1;
                           state_in      = ST_PREFIX;
                        end else begin
                           mag_in   = req_data.arg;
                           state_in = ST_DABBLE;
                        end
                     end
                     CH_U: begin
                        hex_in   = 1'b0;
                        upper_in = 1'b0;
                        mag_in   = req_data.arg;
                        state_in = ST_DABBLE;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_PREFIX: begin
            if (can_emit) begin
               emit_go    = 1'b1;
               emit_char  = pre0_ff;
               emit_last  = (pre_cnt_ff == 2'd1) && !has_digits_ff;
               pre0_in    = pre1_ff;
               pre_cnt_in = pre_cnt_ff - 2'd1;
               if (pre_cnt_ff == 2'd1) begin
                  if (!has_digits_ff) begin
                     state_in = ST_IDLE;
                  end else if (hex_ff) begin
                     state_in = ST_DIGITS;
                  end else begin
                     state_in = ST_DABBLE;
                  end
               end
            end
         end
         ST_DABBLE: begin
            cell_op    = OP_DABBLE;
            mag_in     = {mag_ff[ARG_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(ARG_W - 1)) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            // drop leading zeros without waiting on the output side
            if (!show || can_emit) begin
               cell_op    = OP_SHIFT;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
               started_in = started_ff || show;
               emit_go    = show;
               emit_char  = digit_ascii(top_digit, upper_ff);
               emit_last  = (dig_cnt_ff == DIG_CNT_W'(1));
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_go) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_char = emit_char;
         rsp_data_in.last     = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // digit cell chain; cell NUM_CELLS-1 holds the most significant digit
   genvar gi;
   generate
      for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
         cell_ctl_type       ctl;
         logic               bit_in;
         logic [DIGIT_W-1:0] load_digit;
         logic [DIGIT_W-1:0] digit_below;

         if (gi == 0) begin : g_first
            assign bit_in      = mag_ff[ARG_W-1];
            assign digit_below = '0;
         end else begin : g_next
            assign bit_in      = cell_carry[gi-1];
            assign digit_below = cell_digit[gi-1];
         end

         if (gi < NUM_NIBBLE) begin : g_nib
            assign load_digit = load_hex ? req_data.arg[gi*DIGIT_W +: DIGIT_W] : '0;
         end else begin : g_pad
            assign load_digit = '0;
         end

         assign ctl = {cell_op, bit_in};

         pfmt_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .load_digit (load_digit),
            .digit_in   (digit_below),
            .digit_out  (cell_digit[gi]),
            .carry_out  (cell_carry[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pre_cnt_ff    <= pre_cnt_in;
      pre0_ff       <= pre0_in;
      pre1_ff       <= pre1_in;
      has_digits_ff <= has_digits_in;
      hex_ff        <= hex_in;
      upper_ff      <= upper_in;
      mag_ff        <= mag_in;
      bit_cnt_ff    <= bit_cnt_in;
      dig_cnt_ff    <= dig_cnt_in;
      started_ff    <= started_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTH
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_go && emit_last) |=> (state_ff == ST_IDLE))
      else $error("last character sent but sequencer not idle");

   a_dabble_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DABBLE && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("output produced during digit conversion");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) |-> (dig_cnt_ff != '0))
      else $error("digit counter ran out in digit phase");

   a_prefix_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREFIX) |-> (pre_cnt_ff != 2'd0))
      else $error("prefix phase with no prefix characters");

   a_idle_after_emit_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS && show && !can_emit) |=> $stable(dig_cnt_ff))
      else $error("digit advanced while output register was full");
`endif

endmodule

FILE: sim/tb.sv
// Testbench for printf_integer_formatter: directed and random format streams checked against a predictor.
`timescale 1ns / 1ps
module tb
   import pfmt_pkg::*;
();

   localparam logic [CHAR_W-1:0] CH_S_LO = 8'h73;  // unsupported conversion letter
   localparam logic [7*CHAR_W-1:0] CONV_LETTERS =
      {CH_C, CH_D, CH_U, CH_X_LO, CH_X_UP, CH_P, CH_PERCENT};
   localparam int NUM_LETTERS    = 7;
   localparam int RANDOM_ITEMS   = 94;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;

   class char_ledger;
      rsp_type           expected_chars[$];
      logic [CHAR_W-1:0] spelled[$];
      bit                percent_pending;
      int                errors;

      function void spell_decimal(logic [ARG_W-1:0] v);
         logic [CHAR_W-1:0] digits[$];
         if (v == 0) begin
            spelled.push_back(CH_ZERO);
            return;
         end
         while (v != 0) begin
            digits.push_front(CH_ZERO + CHAR_W'(v % 10));
            v = v / 10;
         end
         foreach (digits[i]) spelled.push_back(digits[i]);
      endfunction

      function void spell_hex(logic [ARG_W-1:0] v, bit upper);
         string             glyphs;
         logic [CHAR_W-1:0] digits[$];
         glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
         if (v == 0) begin
            spelled.push_back(CH_ZERO);
            return;
         end
         while (v != 0) begin
            digits.push_front(glyphs[int'(v[3:0])]);
            v = v >> 4;
         end
         foreach (digits[i]) spelled.push_back(digits[i]);
      endfunction

      // Predict the characters one accepted format byte produces.
      function void note_transfer(req_type item);
         rsp_type one;
         spelled.delete();
         if (item.restart) percent_pending = 1'b0;
         if (item.fmt_char == CH_NUL) begin
            percent_pending = 1'b0;
            return;
         end
         if (!percent_pending) begin
            if (item.fmt_char == CH_PERCENT) begin
               percent_pending = 1'b1;
               return;
            end
            spelled.push_back(item.fmt_char);
         end else begin
            percent_pending = 1'b0;
            case (item.fmt_char)
               CH_C: spelled.push_back(item.arg[CHAR_W-1:0]);
               CH_P: begin
                  spelled.push_back(CH_ZERO);
                  spelled.push_back(CH_X_LO);
                  spell_hex(item.arg, 1'b0);
               end
               CH_D: begin
                  if (item.arg[ARG_W-1]) begin
                     spelled.push_back(CH_MINUS);
                     spell_decimal(~item.arg + 1'b1);
                  end else begin
                     spell_decimal(item.arg);
                  end
               end
               CH_U: spell_decimal(item.arg);
               CH_X_LO: spell_hex(item.arg, 1'b0);
               CH_X_UP: spell_hex(item.arg, 1'b1);
               CH_PERCENT: spelled.push_back(CH_PERCENT);
               default: ;
            endcase
         end
         foreach (spelled[k]) begin
            one.out_char = spelled[k];
            one.last     = (k == spelled.size() - 1);
            expected_chars.push_back(one);
         end
      endfunction

      function void check_char(rsp_type got);
         rsp_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected character: out_char %h last %b", got.out_char, got.last);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, got.out_char);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   char_ledger ledger = new();
   bit         stalls_on;
   int         stall_left;
   int         idle_cycles;
   int         items_sent;

   printf_integer_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Result side: check each transfer, stall in bursts, watch for a hang.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) ledger.check_char(rsp_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("printf_integer_formatter: mismatch");
            $finish;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Call at a rising edge; returns at the edge of the transfer with valid still high.
   task automatic send_item(input logic [CHAR_W-1:0] fmt_char, input logic [ARG_W-1:0] arg,
                            input logic restart);
      req_type item;
      item.fmt_char = fmt_char;
      item.arg      = arg;
      item.restart  = restart;
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      ledger.note_transfer(item);
      items_sent++;
   endtask

   task automatic send_conversion(input logic [CHAR_W-1:0] letter, input logic [ARG_W-1:0] arg);
      send_item(CH_PERCENT, $urandom, 1'b0);
      send_item(letter, arg, 1'b0);
   endtask

   function automatic logic [ARG_W-1:0] pick_arg();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 99);
         2: return {1'b1, 31'($urandom)};
         3: return 32'h1 << $urandom_range(0, 31);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
      endcase
   endfunction

   initial begin
      int                random_start;
      int                pick;
      logic              rst;
      logic [CHAR_W-1:0] letter;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      stalls_on = 1'b1;
      items_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every conversion, and the corner cases
      send_item(8'h41, 32'h0, 1'b1);
      send_item(8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_conversion(CH_D, 32'h8000_0000);   // most negative value, eleven characters
      send_conversion(CH_D, 32'hFFFF_FFFF);
      send_conversion(CH_U, 32'hFFFF_FFFF);
      send_conversion(CH_X_LO, 32'h0);
      send_conversion(CH_X_UP, 32'hDEAD_BEEF);
      send_conversion(CH_P, 32'hFFFF_FFFF);
      send_conversion(CH_C, 32'hFFFF_FF00);   // zero byte still gives one character
      send_conversion(CH_PERCENT, 32'h1234_5678);
      send_conversion(CH_S_LO, 32'h1);        // unsupported letter: nothing
      send_conversion(CH_NUL, 32'h0);         // end of string drops the pending percent
      send_item(CH_PERCENT, 32'h0, 1'b0);
      send_item(CH_D, 32'h5, 1'b1);           // restart clears the percent: echo
      send_item(CH_PERCENT, 32'h0, 1'b1);     // percent with restart starts a conversion
      send_item(CH_U, 32'h7FFF_FFFF, 1'b0);

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         // mix stretches with and without idling; none near the end
         stalls_on = (items_sent - random_start < RANDOM_ITEMS - 20) &&
                     ((items_sent % 30) < 22);
         pick = $urandom_range(0, 9);
         rst  = ($urandom_range(0, 7) == 0);
         if (pick < 6) begin
            letter = CONV_LETTERS[CHAR_W*$urandom_range(0, NUM_LETTERS-1) +: CHAR_W];
            send_item(CH_PERCENT, $urandom, rst);
            send_item(letter, pick_arg(), 1'b0);
         end else if (pick < 8) begin
            send_item(CHAR_W'($urandom_range(8'h20, 8'h7E)), $urandom, rst);
         end else begin
            case ($urandom_range(0, 3))
               0: send_item(CHAR_W'($urandom_range(0, 255)), $urandom, rst);
               1: send_conversion(CH_NUL, $urandom);
               2: send_conversion($urandom_range(0, 1) ? CH_S_LO : CHAR_W'($urandom), $urandom);
               default: begin
                  letter = CONV_LETTERS[CHAR_W*$urandom_range(0, NUM_LETTERS-1) +: CHAR_W];
                  send_item(CH_PERCENT, $urandom, 1'b0);
                  send_item(letter, pick_arg(), 1'b1);
               end
            endcase
         end
      end
      stalls_on = 1'b0;
      req_valid <= 1'b0;

      while (ledger.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("printf_integer_formatter: match");
      end else begin
         $display("printf_integer_formatter: mismatch");
      end
      $finish;
   end

endmodule
